>>> hdl/grain_pkg.sv
// ----------------------------------------------------------------------------
// grain_pkg
// Shared types, constants and cipher step functions for the Grain v1 core.
// ----------------------------------------------------------------------------
package grain_pkg;

  // cipher clocks run after key/IV load
  localparam int INIT_CLOCKS = 160;
  // cipher clocks per cycle in the unrolled update (one byte)
  localparam int STEP_LANES  = 8;
  // remaining-clock counter, wide enough for the init count and one lane group
  localparam int CNT_MAX = (INIT_CLOCKS > STEP_LANES) ? INIT_CLOCKS : STEP_LANES;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam int REG_BITS = 80;
  localparam int IV_BYTES = 8;

  // opcode field (in_tuser)
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_IV_VALUE = 2'd2;
  localparam logic [1:0] CFG_IV_LEN   = 2'd3;

  localparam logic [3:0] IV_LEN_RESET = 4'd8;

  // both shift registers; bit 0 is the oldest, new bits enter at bit 79
  typedef struct packed {
    logic [REG_BITS-1:0] lfsr;
    logic [REG_BITS-1:0] nfsr;
  } grain_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // load NFSR from key, LFSR from IV
    logic step8;      // advance eight cipher clocks
    logic step1;      // advance one cipher clock
    logic fb;         // feed output bit back (initialization)
    logic emit_byte;  // capture a data result word
    logic emit_init;  // capture an init acknowledge word
  } grain_cmd_t;

  // keystream bit of the current state
  function automatic logic grain_z(grain_state_t st);
    logic x0, x1, x2, x3, x4, h;
    x0 = st.lfsr[3];
    x1 = st.lfsr[25];
    x2 = st.lfsr[46];
    x3 = st.lfsr[64];
    x4 = st.nfsr[63];
    h = x1 ^ x4 ^ (x0 & x3) ^ (x2 & x3) ^ (x3 & x4)
      ^ (x0 & x1 & x2) ^ (x0 & x2 & x3) ^ (x0 & x2 & x4)
      ^ (x1 & x2 & x4) ^ (x2 & x3 & x4);
    return st.nfsr[1] ^ st.nfsr[2] ^ st.nfsr[4] ^ st.nfsr[10] ^ st.nfsr[31]
         ^ st.nfsr[43] ^ st.nfsr[56] ^ h;
  endfunction

  // one cipher clock; with fb set the output bit enters both feedbacks
  function automatic grain_state_t grain_step(grain_state_t st, logic fb);
    logic [REG_BITS-1:0] s, b;
    logic z, fs, gb;
    grain_state_t res;
    s  = st.lfsr;
    b  = st.nfsr;
    z  = grain_z(st);
    fs = s[62] ^ s[51] ^ s[38] ^ s[23] ^ s[13] ^ s[0];
    gb = s[0] ^ b[62] ^ b[60] ^ b[52] ^ b[45] ^ b[37] ^ b[33]
       ^ b[28] ^ b[21] ^ b[14] ^ b[9] ^ b[0]
       ^ (b[63] & b[60]) ^ (b[37] & b[33]) ^ (b[15] & b[9])
       ^ (b[60] & b[52] & b[45]) ^ (b[33] & b[28] & b[21])
       ^ (b[63] & b[45] & b[28] & b[9])
       ^ (b[60] & b[52] & b[37] & b[33])
       ^ (b[63] & b[60] & b[21] & b[15])
       ^ (b[63] & b[60] & b[52] & b[45] & b[37])
       ^ (b[33] & b[28] & b[21] & b[15] & b[9])
       ^ (b[52] & b[45] & b[37] & b[33] & b[28] & b[21]);
    res.lfsr = {fs ^ (fb & z), s[REG_BITS-1:1]};
    res.nfsr = {gb ^ (fb & z), b[REG_BITS-1:1]};
    return res;
  endfunction

endpackage

>>> hdl/grain_v1_stream_cipher.sv
// ----------------------------------------------------------------------------
// grain_v1_stream_cipher
// Grain v1 stream cipher with word streams in and out and a write-only
// configuration port for key and IV.
// ----------------------------------------------------------------------------
// A data word (in_tuser = 1) is taken in one cycle and its result, the data
// byte XOR eight keystream bits (first bit in the lsb), is registered the
// cycle after; a new data word can be taken every cycle while the output
// side keeps up. An init word (in_tuser = 0) loads the NFSR from the key and
// the LFSR from the IV padded with ones, then runs 160 cipher clocks with
// output feedback through the eight-lane unrolled update, during which no
// word is taken; it is acknowledged by a result word of zero with
// out_tuser = 1. Key and IV are to be written only while the block is idle;
// the block itself does not enforce this. They take effect at the next init word.
module grain_v1_stream_cipher
  import grain_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] was_init
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] key_low_r;
  logic [15:0] key_high_r;
  logic [63:0] iv_value_r;
  logic [3:0]  iv_len_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_init_r;
  logic        out_free;
  logic [7:0]  ks_byte;
  grain_cmd_t  cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      iv_value_r <= '0;
      iv_len_r   <= IV_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata[15:0];
        CFG_IV_VALUE: iv_value_r <= cfg_wdata;
        CFG_IV_LEN:   iv_len_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;

  grain_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  grain_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .key     ({key_high_r, key_low_r}),
    .iv      (iv_value_r),
    .iv_len  (iv_len_r),
    .ks_byte (ks_byte)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_init) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_byte_r <= in_tdata ^ ks_byte;
      out_init_r <= 1'b0;
    end else if (cmd.emit_init) begin
      out_byte_r <= '0;
      out_init_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_init_r;

`ifndef SYNTH
  // an init word holds off the input in the cycle after it is taken
  a_init_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_INIT) |=> !in_tready)
    else $error("input taken during initialization");

  // the init acknowledge never overwrites a pending result word
  a_init_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_init |-> out_free)
    else $error("init acknowledge would drop a result word");

  // at most one state update per cycle
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step8, cmd.step1}))
    else $error("conflicting state update commands");
`endif

endmodule

>>> hdl/grain_ctrl.sv
// ----------------------------------------------------------------------------
// grain_ctrl
// Sequencer: accepts words, runs the initialization clocks, issues commands.
// ----------------------------------------------------------------------------
module grain_ctrl
  import grain_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_opcode,
  input  logic       out_free,
  output logic       in_ready,
  output grain_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_INIT = 2'b10
  } ctrl_state_t;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             accept;

  localparam logic [CNT_W-1:0] LANES_C = CNT_W'(STEP_LANES);
  localparam logic [CNT_W-1:0] INIT_C  = CNT_W'(INIT_CLOCKS);

  // word taken only while idle and the result slot is free
  assign accept = in_valid && out_free && (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    remain_nxt = remain_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          if (in_opcode == OP_INIT) begin
            cmd.load   = 1'b1;
            remain_nxt = INIT_C;
            state_nxt  = ST_INIT;
          end else begin
            cmd.step8     = 1'b1;
            cmd.emit_byte = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd.fb = 1'b1;
        // eight-lane group steps while enough remain, then single steps
        if (remain_r >= LANES_C) begin
          cmd.step8  = 1'b1;
          remain_nxt = remain_r - LANES_C;
        end else begin
          cmd.step1  = 1'b1;
          remain_nxt = remain_r - CNT_W'(1);
        end
        if (remain_nxt == '0) begin
          cmd.emit_init = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

>>> hdl/grain_dp.sv
// ----------------------------------------------------------------------------
// grain_dp
// Datapath: LFSR/NFSR state, key/IV load and an eight-lane unrolled update.
// ----------------------------------------------------------------------------
module grain_dp
  import grain_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  grain_cmd_t          cmd,
  input  logic [REG_BITS-1:0] key,
  input  logic [63:0]         iv,
  input  logic [3:0]          iv_len,
  output logic [7:0]          ks_byte
);

  grain_state_t state_r, state_nxt;
  grain_state_t chain [STEP_LANES+1];
  grain_state_t loaded;
  logic [STEP_LANES-1:0] z;

  // eight cipher clocks chained; taps never reach bits entered in this group
  always_comb begin
    chain[0] = state_r;
    for (int k = 0; k < STEP_LANES; k++) begin
      z[k]         = grain_z(chain[k]);
      chain[k + 1] = grain_step(chain[k], cmd.fb);
    end
  end

  // keystream bits, first clock in the lsb
  assign ks_byte = z[7:0];

  // key/IV load; IV bytes past the used length read as ones
  always_comb begin
    loaded.nfsr = key;
    loaded.lfsr = '1;
    for (int i = 0; i < IV_BYTES; i++) begin
      if (4'(i) < iv_len) begin
        loaded.lfsr[8*i +: 8] = iv[8*i +: 8];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cmd.load) begin
      state_nxt = loaded;
    end else if (cmd.step8) begin
      state_nxt = chain[STEP_LANES];
    end else if (cmd.step1) begin
      state_nxt = chain[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
